// ===== src/barometric_pressure_compensation_top_defines.svh =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// overlapping implication, reset disables the attempt
`define BPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpc assertion failed");

// next-cycle implication, reset disables the attempt
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpc assertion failed");

`endif

// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Transaction types, register indexes and compensation constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [23:0] raw_press_bytes;
   } bpc_req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic signed [31:0] pressure_pa;
      logic               fault;
   } bpc_rsp_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AC1_AC2 = 3'd0,
      CSR_AC3_AC4 = 3'd1,
      CSR_AC5_AC6 = 3'd2,
      CSR_B1_B2   = 3'd3,
      CSR_MC_MD   = 3'd4,
      CSR_OSS     = 3'd5
   } bpc_csr_type;

   localparam int unsigned DIV1_NUM_W = 27;
   localparam int unsigned DIV1_DEN_W = 18;
   localparam int unsigned DIV2_NUM_W = 32;
   localparam int unsigned DIV2_DEN_W = 17;

   localparam int unsigned BPC_LATENCY = DIV1_NUM_W + DIV2_NUM_W + 10;

   localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
   localparam logic signed [12:0] PRESS_C1    = 13'sd3038;
   localparam logic signed [13:0] PRESS_C2    = -14'sd7357;
   localparam logic signed [17:0] PRESS_C3    = 18'sd3791;
   localparam logic [15:0]        OSS_SCALE   = 16'd50000;
   localparam logic signed [18:0] B4_OFFSET   = 19'sd32768;

endpackage

`default_nettype wire

// ===== src/bpc_udiv.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a tag.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_udiv
   import bpc_pkg::*;
#(
   parameter int unsigned NUM_W = DIV2_NUM_W,
   parameter int unsigned DEN_W = DIV2_DEN_W,
   parameter int unsigned TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic      [NUM_W-1:0] out_quo,
   output logic      [TAG_W-1:0] out_tag
);

   logic             valid_ff [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [TAG_W-1:0] tag_ff   [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic             valid_prev;
      logic [NUM_W-1:0] num_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W+1:0] diff;
      logic             ge;
      logic [NUM_W-1:0] num_in;
      logic [DEN_W-1:0] rem_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign num_prev   = in_num;
         assign rem_prev   = '0;
         assign den_prev   = in_den;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign num_prev   = num_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign tag_prev   = tag_ff[i-1];
      end

      assign trial  = {rem_prev, num_prev[NUM_W-1]};
      assign diff   = {1'b0, trial} - {2'b00, den_prev};
      assign ge     = ~diff[DEN_W+1];
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign num_in = {num_prev[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         num_ff[i] <= num_in;
         rem_ff[i] <= rem_in;
         den_ff[i] <= den_prev;
         tag_ff[i] <= tag_prev;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

`default_nettype wire

// ===== src/barometric_pressure_compensation_top.sv =====
// Path: stage 1, temperature divider, stages 3-7, pressure divider, 9-12.
// Throughput: one transaction per cycle; the two bit-per-stage dividers
// (27 and 32 stages) set the depth, every stage takes a new item each cycle.
// Reset (synchronous) clears all valid bits and the calibration registers;
// busy is high only during reset. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
// Barometric pressure compensation top level
// Integer temperature and pressure compensation in a deep pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_top
   import bpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire bpc_req_type            req_payload,
   output logic                        rsp_strobe,
   output bpc_rsp_type                 rsp_payload,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef struct packed {
      logic signed [16:0] x1;
      logic [23:0]        up;
      logic               neg;
      logic               zero;
   } div1_tag_type;

   typedef struct packed {
      logic               fault;
      logic signed [15:0] temp;
      logic               half;
   } div2_tag_type;

   // calibration registers
   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AC1_AC2: ac1_ac2_ff <= csr_wdata;
            CSR_AC3_AC4: ac3_ac4_ff <= csr_wdata;
            CSR_AC5_AC6: ac5_ac6_ff <= csr_wdata;
            CSR_B1_B2:   b1_b2_ff   <= csr_wdata;
            CSR_MC_MD:   mc_md_ff   <= csr_wdata;
            CSR_OSS:     oss_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = ac1_ac2_ff[31:16];
   assign ac2 = ac1_ac2_ff[15:0];
   assign ac3 = ac3_ac4_ff[31:16];
   assign ac4 = ac3_ac4_ff[15:0];
   assign ac5 = ac5_ac6_ff[31:16];
   assign ac6 = ac5_ac6_ff[15:0];
   assign b1  = b1_b2_ff[31:16];
   assign b2  = b1_b2_ff[15:0];
   assign mc  = mc_md_ff[31:16];
   assign md  = mc_md_ff[15:0];

   assign busy = reset;

   logic accept;
   assign accept = start & ~busy;

   // stage 1: temperature product, pressure word
   logic signed [16:0] ut_diff;
   logic signed [34:0] p1_full;
   logic               v1_ff;
   logic signed [31:0] p1_prod_ff;
   logic [23:0]        p1_up_ff;

   assign ut_diff = $signed({1'b0, req_payload.raw_temp}) - $signed({1'b0, ac6});
   assign p1_full = ut_diff * $signed({1'b0, ac5});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      p1_prod_ff <= p1_full[31:0];
      p1_up_ff   <= 24'(req_payload.raw_press_bytes >> (4'd8 - {2'b00, oss_ff}));
   end

   // temperature divider
   logic signed [16:0]      d1_x1;
   logic signed [17:0]      d1_div;
   logic [15:0]             d1_mc_mag;
   logic [DIV1_DEN_W-1:0]   d1_den;
   div1_tag_type            d1_tag_in, d1_tag_out;
   logic                    d1_valid;
   logic [DIV1_NUM_W-1:0]   d1_quo;

   assign d1_x1     = 17'(p1_prod_ff >>> 15);
   assign d1_div    = 18'(d1_x1) + 18'(md);
   assign d1_mc_mag = mc[15] ? 16'(-mc) : mc;
   assign d1_den    = d1_div[17] ? 18'(-d1_div) : d1_div;

   assign d1_tag_in.x1   = d1_x1;
   assign d1_tag_in.up   = p1_up_ff;
   assign d1_tag_in.neg  = mc[15] ^ d1_div[17];
   assign d1_tag_in.zero = (d1_div == '0);

   bpc_udiv #(
      .NUM_W (DIV1_NUM_W),
      .DEN_W (DIV1_DEN_W),
      .TAG_W ($bits(div1_tag_type))
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_num    ({d1_mc_mag, 11'b0}),
      .in_den    (d1_den),
      .in_tag    (d1_tag_in),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag_out)
   );

   // stage 3: b5, temperature, b6
   logic signed [27:0] s3_x2;
   logic signed [28:0] s3_b5;
   logic signed [28:0] s3_t;
   logic signed [15:0] s3_temp;
   logic               v3_ff;
   logic signed [29:0] s3_b6_ff;
   logic signed [15:0] s3_temp_ff;
   logic               s3_fault_ff;
   logic [23:0]        s3_up_ff;

   assign s3_x2 = d1_tag_out.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
   assign s3_b5 = 29'(d1_tag_out.x1) + 29'(s3_x2);
   assign s3_t  = (s3_b5 + 29'sd8) >>> 4;

   always_comb begin
      priority if (s3_t > 29'sd32767) begin
         s3_temp = 16'sh7fff;
      end else if (s3_t < -29'sd32768) begin
         s3_temp = 16'sh8000;
      end else begin
         s3_temp = s3_t[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_b6_ff    <= 30'(s3_b5) - B6_OFFSET;
      s3_temp_ff  <= s3_temp;
      s3_fault_ff <= d1_tag_out.zero;
      s3_up_ff    <= d1_tag_out.up;
   end

   // stage 4: b6 products
   logic signed [59:0] s4_sq_full;
   logic signed [45:0] s4_a2_full, s4_a3_full;
   logic               v4_ff;
   logic signed [31:0] s4_sq_ff, s4_a2_ff, s4_a3_ff;
   logic signed [15:0] s4_temp_ff;
   logic               s4_fault_ff;
   logic [23:0]        s4_up_ff;

   assign s4_sq_full = s3_b6_ff * s3_b6_ff;
   assign s4_a2_full = ac2 * s3_b6_ff;
   assign s4_a3_full = ac3 * s3_b6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_sq_ff    <= s4_sq_full[31:0];
      s4_a2_ff    <= s4_a2_full[31:0];
      s4_a3_ff    <= s4_a3_full[31:0];
      s4_temp_ff  <= s3_temp_ff;
      s4_fault_ff <= s3_fault_ff;
      s4_up_ff    <= s3_up_ff;
   end

   // stage 5: square products
   logic signed [19:0] s5_sq;
   logic signed [35:0] s5_b2_full, s5_b1_full;
   logic               v5_ff;
   logic signed [31:0] s5_b2sq_ff, s5_b1sq_ff;
   logic signed [20:0] s5_a2_ff;
   logic signed [18:0] s5_a3_ff;
   logic signed [15:0] s5_temp_ff;
   logic               s5_fault_ff;
   logic [23:0]        s5_up_ff;

   assign s5_sq      = 20'(s4_sq_ff >>> 12);
   assign s5_b2_full = b2 * s5_sq;
   assign s5_b1_full = b1 * s5_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_b2sq_ff  <= s5_b2_full[31:0];
      s5_b1sq_ff  <= s5_b1_full[31:0];
      s5_a2_ff    <= 21'(s4_a2_ff >>> 11);
      s5_a3_ff    <= 19'(s4_a3_ff >>> 13);
      s5_temp_ff  <= s4_temp_ff;
      s5_fault_ff <= s4_fault_ff;
      s5_up_ff    <= s4_up_ff;
   end

   // stage 6: b3 and x3
   logic signed [21:0] s6_x3;
   logic signed [22:0] s6_sum;
   logic signed [26:0] s6_scaled;
   logic signed [19:0] s6_x3p_sum;
   logic               v6_ff;
   logic signed [31:0] s6_b3_ff;
   logic signed [17:0] s6_x3p_ff;
   logic signed [15:0] s6_temp_ff;
   logic               s6_fault_ff;
   logic [23:0]        s6_up_ff;

   assign s6_x3      = 22'(s5_b2sq_ff >>> 11) + 22'(s5_a2_ff);
   assign s6_sum     = (23'(ac1) <<< 2) + 23'(s6_x3);
   assign s6_scaled  = (27'(s6_sum) <<< oss_ff) + 27'sd2;
   assign s6_x3p_sum = 20'(s5_a3_ff) + 20'(s5_b1sq_ff >>> 16) + 20'sd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_b3_ff    <= 32'(s6_scaled >>> 2);
      s6_x3p_ff   <= 18'(s6_x3p_sum >>> 2);
      s6_temp_ff  <= s5_temp_ff;
      s6_fault_ff <= s5_fault_ff;
      s6_up_ff    <= s5_up_ff;
   end

   // stage 7: b4 and b7 products
   logic signed [18:0] s7_v;
   logic [31:0]        s7_v32;
   logic [47:0]        s7_b4_full, s7_b7_full;
   logic [15:0]        s7_scale;
   logic               v7_ff;
   logic [31:0]        s7_b4p_ff, s7_b7_ff;
   logic signed [15:0] s7_temp_ff;
   logic               s7_fault_ff;

   assign s7_v       = 19'(s6_x3p_ff) + B4_OFFSET;
   assign s7_v32     = 32'(s7_v);
   assign s7_scale   = OSS_SCALE >> oss_ff;
   assign s7_b4_full = ac4 * s7_v32;
   assign s7_b7_full = ({8'b0, s6_up_ff} - unsigned'(s6_b3_ff)) * s7_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_b4p_ff   <= s7_b4_full[31:0];
      s7_b7_ff    <= s7_b7_full[31:0];
      s7_temp_ff  <= s6_temp_ff;
      s7_fault_ff <= s6_fault_ff;
   end

   // pressure divider
   logic [DIV2_DEN_W-1:0] d2_den;
   logic [DIV2_NUM_W-1:0] d2_num;
   div2_tag_type          d2_tag_in, d2_tag_out;
   logic                  d2_valid;
   logic [DIV2_NUM_W-1:0] d2_quo;

   assign d2_den = s7_b4p_ff[31:15];
   assign d2_num = s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0};

   assign d2_tag_in.fault = s7_fault_ff | (d2_den == '0);
   assign d2_tag_in.temp  = s7_temp_ff;
   assign d2_tag_in.half  = s7_b7_ff[31];

   bpc_udiv #(
      .NUM_W (DIV2_NUM_W),
      .DEN_W (DIV2_DEN_W),
      .TAG_W ($bits(div2_tag_type))
   ) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num    (d2_num),
      .in_den    (d2_den),
      .in_tag    (d2_tag_in),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_tag   (d2_tag_out)
   );

   // stage 9: raw pressure
   logic signed [31:0] s9_p;
   logic               v9_ff;
   logic signed [31:0] s9_p_ff;
   logic signed [23:0] s9_a_ff;
   logic signed [15:0] s9_temp_ff;
   logic               s9_fault_ff;

   assign s9_p = d2_tag_out.half ? {d2_quo[30:0], 1'b0} : d2_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      s9_p_ff     <= s9_p;
      s9_a_ff     <= 24'(s9_p >>> 8);
      s9_temp_ff  <= d2_tag_out.temp;
      s9_fault_ff <= d2_tag_out.fault;
   end

   // stage 10: pressure square and linear term
   logic signed [47:0] s10_sq_full;
   logic signed [45:0] s10_m7_full;
   logic               v10_ff;
   logic signed [31:0] s10_sq_ff, s10_m7_ff, s10_p_ff;
   logic signed [15:0] s10_temp_ff;
   logic               s10_fault_ff;

   assign s10_sq_full = s9_a_ff * s9_a_ff;
   assign s10_m7_full = s9_p_ff * PRESS_C2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      s10_sq_ff    <= s10_sq_full[31:0];
      s10_m7_ff    <= s10_m7_full[31:0];
      s10_p_ff     <= s9_p_ff;
      s10_temp_ff  <= s9_temp_ff;
      s10_fault_ff <= s9_fault_ff;
   end

   // stage 11: quadratic term
   logic signed [44:0] s11_m3_full;
   logic               v11_ff;
   logic signed [31:0] s11_m3_ff, s11_p_ff;
   logic signed [15:0] s11_x2_ff, s11_temp_ff;
   logic               s11_fault_ff;

   assign s11_m3_full = s10_sq_ff * PRESS_C1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else begin
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      s11_m3_ff    <= s11_m3_full[31:0];
      s11_x2_ff    <= 16'(s10_m7_ff >>> 16);
      s11_p_ff     <= s10_p_ff;
      s11_temp_ff  <= s10_temp_ff;
      s11_fault_ff <= s10_fault_ff;
   end

   // stage 12: correction and result register
   logic signed [17:0] s12_corr;
   logic signed [31:0] s12_press;
   logic               rsp_strobe_ff;
   bpc_rsp_type        rsp_payload_ff;

   assign s12_corr  = 18'(s11_m3_ff >>> 16) + 18'(s11_x2_ff) + PRESS_C3;
   assign s12_press = s11_p_ff + 32'(s12_corr >>> 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff.fault       <= s11_fault_ff;
      rsp_payload_ff.temp_tenths <= s11_fault_ff ? '0 : s11_temp_ff;
      rsp_payload_ff.pressure_pa <= s11_fault_ff ? '0 : s12_press;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== src/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation checker
// Port-level timing and fault checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "barometric_pressure_compensation_top_defines.svh"

module bpc_checker
   import bpc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire bpc_rsp_type rsp_payload
);

   logic accepted;
   logic rsp_zero;

   assign accepted = start && !busy;
   assign rsp_zero = (rsp_payload.pressure_pa == '0) && (rsp_payload.temp_tenths == '0);

   `BPC_ASSERT_NEXT(a_result_follows, clock, reset, accepted, ##(BPC_LATENCY-1) rsp_strobe)
   `BPC_ASSERT_IMPL(a_result_has_cause, clock, reset, rsp_strobe, $past(accepted, BPC_LATENCY))
   `BPC_ASSERT_IMPL(a_fault_zeroes, clock, reset, rsp_strobe && rsp_payload.fault, rsp_zero)

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Drives raw sensor transactions through the compensation pipeline under
// several calibration settings and checks every result, field by field,
// against an integer predictor kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import bpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   bpc_req_type            req_payload = '0;
   logic                   rsp_strobe;
   bpc_rsp_type            rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [31:0] cal_word [0:4];
   logic [1:0]  cal_oss;
   bpc_rsp_type expected_rsp_q [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_pct = 0;

   barometric_pressure_compensation_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint w32(longint x);
      return longint'(int'(x));
   endfunction

   function automatic bpc_rsp_type compensate(bpc_req_type rq);
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint ut, x1, x2, x3, dv, b5, b6, b3, t, p, sq;
      int unsigned oss;
      logic [31:0] up, b4, b7, pu, x3u;
      logic [63:0] wide;
      bpc_rsp_type rsp;
      ac1 = longint'($signed(cal_word[0][31:16]));
      ac2 = longint'($signed(cal_word[0][15:0]));
      ac3 = longint'($signed(cal_word[1][31:16]));
      ac4 = longint'(cal_word[1][15:0]);
      ac5 = longint'(cal_word[2][31:16]);
      ac6 = longint'(cal_word[2][15:0]);
      b1  = longint'($signed(cal_word[3][31:16]));
      b2  = longint'($signed(cal_word[3][15:0]));
      mc  = longint'($signed(cal_word[4][31:16]));
      md  = longint'($signed(cal_word[4][15:0]));
      oss = cal_oss;
      ut  = longint'(rq.raw_temp);
      up  = {8'd0, rq.raw_press_bytes} >> (8 - oss);
      rsp = '0;
      rsp.fault = 1'b1;

      x1 = w32((ut - ac6) * ac5) >>> 15;
      dv = w32(x1 + md);
      if (dv == 0) return rsp;
      x2 = w32((mc * 2048) / dv);
      b5 = w32(x1 + x2);
      t  = w32(b5 + 8) >>> 4;

      b6 = w32(b5 - longint'(B6_OFFSET));
      sq = w32(b6 * b6) >>> 12;
      x1 = w32(b2 * sq) >>> 11;
      x2 = w32(ac2 * b6) >>> 11;
      x3 = w32(x1 + x2);
      b3 = w32(w32(w32(ac1 * 4 + x3) * (longint'(1) << oss)) + 2) >>> 2;
      x1 = w32(ac3 * b6) >>> 13;
      x2 = w32(b1 * sq) >>> 16;
      x3 = w32(w32(x1 + x2) + 2) >>> 2;

      x3u  = 32'(w32(x3 + longint'(B4_OFFSET)));
      wide = 64'(ac4) * 64'(x3u);
      b4   = wide[31:0] >> 15;
      if (b4 == 0) return rsp;
      wide = 64'(up - 32'(b3)) * 64'(OSS_SCALE >> oss);
      b7   = wide[31:0];
      if (b7 < 32'h8000_0000) pu = (b7 << 1) / b4;
      else pu = (b7 / b4) << 1;
      p = longint'($signed(pu));

      x1 = w32((p >>> 8) * (p >>> 8));
      x1 = w32(x1 * longint'(PRESS_C1)) >>> 16;
      x2 = w32(longint'(PRESS_C2) * p) >>> 16;
      p  = w32(p + (w32(x1 + x2 + longint'(PRESS_C3)) >>> 4));

      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      rsp.temp_tenths = 16'(t);
      rsp.pressure_pa = 32'(p);
      rsp.fault = 1'b0;
      return rsp;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      bpc_rsp_type exp;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            exp = expected_rsp_q.pop_front();
            if (rsp_payload.temp_tenths !== exp.temp_tenths)
               report_mismatch("temp_tenths", rsp_payload.temp_tenths, exp.temp_tenths);
            if (rsp_payload.pressure_pa !== exp.pressure_pa)
               report_mismatch("pressure_pa", rsp_payload.pressure_pa, exp.pressure_pa);
            if (rsp_payload.fault !== exp.fault)
               report_mismatch("fault", rsp_payload.fault, exp.fault);
         end
      end
   end

   task automatic send_sample(logic [15:0] ut, logic [23:0] upb);
      bpc_req_type rq;
      rq.raw_temp = ut;
      rq.raw_press_bytes = upb;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(compensate(rq));
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_AC1_AC2: cal_word[0] = value;
         CSR_AC3_AC4: cal_word[1] = value;
         CSR_AC5_AC6: cal_word[2] = value;
         CSR_B1_B2:   cal_word[3] = value;
         CSR_MC_MD:   cal_word[4] = value;
         CSR_OSS:     cal_oss = value[1:0];
         default: ;
      endcase
   endtask

   task automatic load_calibration(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                   logic [31:0] w3, logic [31:0] w4, logic [31:0] oss);
      drain();
      write_csr(CSR_AC1_AC2, w0);
      write_csr(CSR_AC3_AC4, w1);
      write_csr(CSR_AC5_AC6, w2);
      write_csr(CSR_B1_B2, w3);
      write_csr(CSR_MC_MD, w4);
      write_csr(CSR_OSS, oss);
   endtask

   task automatic load_typical(logic [1:0] oss);
      load_calibration({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                       {-16'sd8711, 16'sd2868}, 32'(oss));
   endtask

   task automatic test_reset_defaults;
      send_sample(16'd27898, 24'h5d2300);
      send_sample(16'hffff, 24'hffffff);
   endtask

   task automatic test_field_extremes;
      for (int o = 0; o < 4; o++) begin
         load_typical(2'(o));
         send_sample(16'd27898, 24'h5d2300);
         send_sample(16'h0000, 24'h000000);
         send_sample(16'hffff, 24'hffffff);
      end
   endtask

   task automatic test_zero_divisors;
      load_calibration(32'h0198ffb8, 32'hc7d10000, 32'h7ff55a71, 32'h182e0004,
                       32'hddf90b34, 32'd1);
      send_sample(16'd27898, 24'h5d2300);
      load_calibration(32'h0198ffb8, 32'hc7d17fe5, 32'h00005a71, 32'h182e0004,
                       32'hddf90000, 32'd3);
      send_sample(16'd1234, 24'h800000);
   endtask

   task automatic test_temp_saturation;
      load_calibration(32'h0198ffb8, 32'hc7d17fe5, 32'h00005a71, 32'h182e0004,
                       32'h7fff0001, 32'd2);
      send_sample(16'd100, 24'h400000);
      drain();
      write_csr(CSR_MC_MD, 32'h80000001);
      send_sample(16'd100, 24'h400000);
      load_calibration(32'h7fff8000, 32'h8000ffff, 32'hffff0000, 32'h7fff8000,
                       32'h8000ffff, 32'd0);
      send_sample(16'hffff, 24'hffffff);
      send_sample(16'h0001, 24'h000001);
   endtask

   task automatic test_spare_index;
      load_typical(2'd1);
      write_csr(CSR_SPARE_A, 32'hffffffff);
      write_csr(CSR_SPARE_B, 32'h00000000);
      send_sample(16'd27898, 24'h5d2300);
   endtask

   task automatic test_random_traffic;
      int unsigned pct [3] = '{14, 68, 0};
      logic [31:0] w [5];
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = pct[ph];
         for (int chunk = 0; chunk < 5; chunk++) begin
            if ($urandom_range(1) == 0) begin
               foreach (w[k]) w[k] = $urandom();
               load_calibration(w[0], w[1], w[2], w[3], w[4], $urandom_range(3));
            end else begin
               load_typical(2'($urandom_range(3)));
               write_csr(CSR_MC_MD, {16'($signed(-8711) + $signed($urandom_range(400)) - 200),
                                     16'd2868 + 16'($urandom_range(300))});
            end
            for (int n = 0; n < 45; n++) begin
               if ($urandom_range(3) == 0)
                  send_sample(16'($urandom()), 24'($urandom()));
               else
                  send_sample(16'($urandom_range(20000, 35000)),
                              24'($urandom_range(24'h400000, 24'hb00000)));
            end
            if (chunk == 2) drain();
         end
      end
      idle_pct = 0;
   endtask

   initial begin
      foreach (cal_word[k]) cal_word[k] = '0;
      cal_oss = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_zero_divisors();
      test_temp_saturation();
      test_spare_index();
      test_random_traffic();
      drain();
      repeat (BPC_LATENCY + 5) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/bpc_pkg.sv
src/bpc_udiv.sv
src/barometric_pressure_compensation_top.sv
src/bpc_checker.sv
bench/tb_top.sv
